@@ src/cst_pkg.sv @@
// shared types, codes and constants for the character stream tokenizer
package cst_pkg;

    // token kinds reported on the result channel
    localparam logic [2:0] KIND_END     = 3'd0;
    localparam logic [2:0] KIND_KW1     = 3'd1;
    localparam logic [2:0] KIND_KW2     = 3'd2;
    localparam logic [2:0] KIND_IDENT   = 3'd3;
    localparam logic [2:0] KIND_NUMBER  = 3'd4;
    localparam logic [2:0] KIND_SINGLE  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_KW1     = 2'd0;
    localparam logic [1:0] CFG_KW1_LEN = 2'd1;
    localparam logic [1:0] CFG_KW2     = 2'd2;
    localparam logic [1:0] CFG_KW2_LEN = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int KW_LEN_W   = 4;

    // reset values: "funk" and "dih", first character in the lowest byte
    localparam logic [CFG_DATA_W-1:0] KW1_RESET     = 64'd1802401126;
    localparam logic [KW_LEN_W-1:0]   KW1_LEN_RESET = 4'd4;
    localparam logic [CFG_DATA_W-1:0] KW2_RESET     = 64'd6842724;
    localparam logic [KW_LEN_W-1:0]   KW2_LEN_RESET = 4'd3;

    localparam int LENGTH_LIMIT_DEF  = 255;
    localparam int KEYWORD_BYTES_DEF = 8;

    // result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [7:0] CHAR_TILDE      = 8'h7E;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;
    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] token_char;
        logic [7:0] token_length;
        logic       last;
    } out_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

@@ src/cst_scanner.sv @@
// scan state, keyword registers and per-character token decisions
module cst_scanner #(
    parameter int LENGTH_LIMIT  = cst_pkg::LENGTH_LIMIT_DEF,
    parameter int KEYWORD_BYTES = cst_pkg::KEYWORD_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_fire,
    input  cst_pkg::in_t                    in_data,
    output logic                            out0_valid,
    output cst_pkg::out_t                   out0,
    output logic                            out1_valid,
    output cst_pkg::out_t                   out1
);

    localparam int KW_W  = 8 * KEYWORD_BYTES;
    localparam int LEN_W = $clog2(LENGTH_LIMIT + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LENGTH_LIMIT);

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_IDENT   = 2'd2;
    localparam logic [1:0] MODE_NUMBER  = 2'd3;

    logic [KW_W-1:0]               kw1_reg, kw2_reg;
    logic [cst_pkg::KW_LEN_W-1:0]  kw1_len_reg, kw2_len_reg;

    logic [1:0]       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             m1_reg, m1_next, m2_reg, m2_next;

    logic [7:0]       ch;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len_sat;
    logic             hit1, hit2;
    logic             flush_v, sec_v;
    cst_pkg::out_t    flush_tok, sec_tok;

    assign ch      = in_data.char_code;
    assign len_sat = (len_reg < LEN_MAX) ? len_reg + LEN_W'(1) : len_reg;
    // a fresh identifier compares its first character at position zero
    assign pos     = (mode_reg == MODE_IDENT) ? len_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw1_reg     <= cst_pkg::KW1_RESET[KW_W-1:0];
            kw1_len_reg <= cst_pkg::KW1_LEN_RESET;
            kw2_reg     <= cst_pkg::KW2_RESET[KW_W-1:0];
            kw2_len_reg <= cst_pkg::KW2_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                cst_pkg::CFG_KW1:     kw1_reg     <= cfg_wdata[KW_W-1:0];
                cst_pkg::CFG_KW1_LEN: kw1_len_reg <= cfg_wdata[cst_pkg::KW_LEN_W-1:0];
                cst_pkg::CFG_KW2:     kw2_reg     <= cfg_wdata[KW_W-1:0];
                cst_pkg::CFG_KW2_LEN: kw2_len_reg <= cfg_wdata[cst_pkg::KW_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // keyword byte compare at the current position
    always_comb begin
        hit1 = 1'b0;
        hit2 = 1'b0;
        for (int i = 0; i < KEYWORD_BYTES; i++) begin
            if (pos == LEN_W'(i)) begin
                hit1 = kw1_reg[8*i +: 8] == ch;
                hit2 = kw2_reg[8*i +: 8] == ch;
            end
        end
        hit1 = hit1 && (pos < LEN_W'(kw1_len_reg));
        hit2 = hit2 && (pos < LEN_W'(kw2_len_reg));
    end

    // token for whatever is pending
    always_comb begin
        flush_v                = (mode_reg == MODE_IDENT) || (mode_reg == MODE_NUMBER);
        flush_tok.token_char   = 8'd0;
        flush_tok.token_length = 8'(len_reg);
        flush_tok.last         = 1'b0;
        if (mode_reg == MODE_NUMBER) begin
            flush_tok.token_kind = cst_pkg::KIND_NUMBER;
        end else if (m1_reg && len_reg == LEN_W'(kw1_len_reg)) begin
            flush_tok.token_kind = cst_pkg::KIND_KW1;
        end else if (m2_reg && len_reg == LEN_W'(kw2_len_reg)) begin
            flush_tok.token_kind = cst_pkg::KIND_KW2;
        end else begin
            flush_tok.token_kind = cst_pkg::KIND_IDENT;
        end
    end

    always_comb begin
        logic emit_flush;
        emit_flush           = 1'b0;
        sec_v                = 1'b0;
        sec_tok.token_kind   = cst_pkg::KIND_END;
        sec_tok.token_char   = 8'd0;
        sec_tok.token_length = 8'd0;
        sec_tok.last         = 1'b1;
        mode_next            = mode_reg;
        len_next             = len_reg;
        m1_next              = m1_reg;
        m2_next              = m2_reg;

        if (in_data.end_of_input) begin
            emit_flush = flush_v;
            sec_v      = 1'b1;
            mode_next  = MODE_IDLE;
            len_next   = '0;
            m1_next    = 1'b0;
            m2_next    = 1'b0;
        end else if (mode_reg == MODE_COMMENT) begin
            if (ch == cst_pkg::CHAR_NEWLINE) begin
                mode_next = MODE_IDLE;
            end
        end else if (mode_reg == MODE_IDENT && (cst_pkg::is_alpha(ch) ||
                     cst_pkg::is_digit(ch) || ch == cst_pkg::CHAR_UNDERSCORE)) begin
            m1_next  = m1_reg && hit1;
            m2_next  = m2_reg && hit2;
            len_next = len_sat;
        end else if (mode_reg == MODE_NUMBER &&
                     (cst_pkg::is_digit(ch) || ch == cst_pkg::CHAR_DOT)) begin
            len_next = len_sat;
        end else begin
            // pending token ends here, then the character is handled from idle
            emit_flush = flush_v;
            mode_next  = MODE_IDLE;
            len_next   = '0;
            m1_next    = 1'b0;
            m2_next    = 1'b0;
            if (cst_pkg::is_space(ch)) begin
                mode_next = MODE_IDLE;
            end else if (ch == cst_pkg::CHAR_TILDE) begin
                mode_next = MODE_COMMENT;
            end else if (cst_pkg::is_alpha(ch) || ch == cst_pkg::CHAR_UNDERSCORE) begin
                mode_next = MODE_IDENT;
                len_next  = LEN_W'(1);
                m1_next   = hit1;
                m2_next   = hit2;
            end else if (cst_pkg::is_digit(ch) || ch == cst_pkg::CHAR_DOT) begin
                mode_next = MODE_NUMBER;
                len_next  = LEN_W'(1);
            end else begin
                sec_v                = 1'b1;
                sec_tok.token_kind   = cst_pkg::KIND_SINGLE;
                sec_tok.token_char   = ch;
                sec_tok.token_length = 8'd1;
            end
        end

        out0_valid = emit_flush || sec_v;
        out1_valid = emit_flush && sec_v;
        out1       = sec_tok;
        if (emit_flush) begin
            out0      = flush_tok;
            out0.last = !sec_v;
        end else begin
            out0 = sec_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            len_reg  <= '0;
            m1_reg   <= 1'b0;
            m2_reg   <= 1'b0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
        end
    end

endmodule

@@ src/cst_out_queue.sv @@
// small result queue taking up to two tokens per cycle and giving one while m_ready is high
module cst_out_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push0,
    input  cst_pkg::out_t data0,
    input  logic          push1,
    input  cst_pkg::out_t data1,
    output logic          room,
    output logic          m_valid,
    input  logic          m_ready,
    output cst_pkg::out_t m_data
);

    cst_pkg::out_t                    mem_reg [cst_pkg::QUEUE_DEPTH];
    logic [cst_pkg::QUEUE_PTR_W-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [cst_pkg::QUEUE_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                             pop;
    logic [cst_pkg::QUEUE_PTR_W-1:0]  wr_alt;

    assign m_valid = cnt_reg != '0;
    assign m_data  = mem_reg[rd_reg];
    assign pop     = m_valid && m_ready;
    // accept only with space for a two-token transaction
    assign room    = cnt_reg <= cst_pkg::QUEUE_CNT_W'(cst_pkg::QUEUE_DEPTH - 2);
    assign wr_alt  = wr_reg + cst_pkg::QUEUE_PTR_W'(1);

    assign wr_next  = wr_reg + cst_pkg::QUEUE_PTR_W'(push0) + cst_pkg::QUEUE_PTR_W'(push1);
    assign rd_next  = rd_reg + cst_pkg::QUEUE_PTR_W'(pop);
    assign cnt_next = cnt_reg + cst_pkg::QUEUE_CNT_W'(push0) + cst_pkg::QUEUE_CNT_W'(push1)
                      - cst_pkg::QUEUE_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push0) begin
            mem_reg[wr_reg] <= data0;
        end
        if (push1) begin
            mem_reg[wr_alt] <= data1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ src/character_stream_tokenizer.sv @@
// a token is written into the result queue when its character is accepted and is offered on m_ from there
// throughput: one character per cycle while s_ready is high; a character ending a token and making
//   another yields two tokens, which leave one after the other
// s_ready drops when the four-entry result queue cannot take two more tokens
// reset: synchronous active-low aresetn clears scan state and queue and
//   loads the keyword registers with "funk" (length 4) and "dih" (length 3)
module character_stream_tokenizer #(
    parameter int LENGTH_LIMIT  = cst_pkg::LENGTH_LIMIT_DEF,
    parameter int KEYWORD_BYTES = cst_pkg::KEYWORD_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cst_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cst_pkg::out_t                   m_data
);

    logic          in_fire;
    logic          out0_valid, out1_valid;
    cst_pkg::out_t out0, out1;

    assign in_fire = s_valid && s_ready;

    cst_scanner #(
        .LENGTH_LIMIT  (LENGTH_LIMIT),
        .KEYWORD_BYTES (KEYWORD_BYTES)
    ) u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_fire    (in_fire),
        .in_data    (s_data),
        .out0_valid (out0_valid),
        .out0       (out0),
        .out1_valid (out1_valid),
        .out1       (out1)
    );

    cst_out_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push0   (in_fire && out0_valid),
        .data0   (out0),
        .push1   (in_fire && out1_valid),
        .data1   (out1),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ src/cst_checker.sv @@
// port-level checks for the character stream tokenizer and their bind
module cst_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          m_valid,
    input logic          m_ready,
    input cst_pkg::out_t m_data
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == cst_pkg::KIND_END |->
        m_data.last && m_data.token_length == 8'd0)
        else $error("end token malformed");

    a_single_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind == cst_pkg::KIND_SINGLE |->
        m_data.token_length == 8'd1)
        else $error("single character token length not one");

    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind != cst_pkg::KIND_SINGLE |->
        m_data.token_char == 8'd0)
        else $error("token char set on a multi-character token");

endmodule

bind character_stream_tokenizer cst_checker u_cst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ verif/character_stream_tokenizer_tb.sv @@
// self-checking testbench for the character stream tokenizer
`timescale 1ns / 1ps

module character_stream_tokenizer_tb;

    localparam logic [7:0] TOKEN_LEN_MAX = 8'd255;
    localparam int KEYWORD_BYTES = 8;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_COMMENT, SCAN_IDENT, SCAN_NUMBER} scan_mode_t;
    typedef enum {CK_SPACE, CK_TILDE, CK_LEAD, CK_DIGIT, CK_DOT, CK_OTHER} char_kind_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_wr_en = 1'b0;
    logic [1:0]    cfg_addr = '0;
    logic [63:0]   cfg_wdata = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    cst_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    cst_pkg::out_t m_data;

    // tokenizer state and keyword registers as the checker sees them
    scan_mode_t    scan_st = SCAN_IDLE;
    logic [7:0]    tok_len = '0;
    logic          kw1_hit = 1'b0;
    logic          kw2_hit = 1'b0;
    logic [63:0]   kw1_word = 64'h6B6E7566;  // "funk"
    logic [3:0]    kw1_len = 4'd4;
    logic [63:0]   kw2_word = 64'h00686964;  // "dih"
    logic [3:0]    kw2_len = 4'd3;

    cst_pkg::in_t  char_q[$];
    cst_pkg::out_t tokens_due[$];
    int            items_queued = 0;
    int            items_taken = 0;
    int            items_counted = 0;
    int            mismatches = 0;
    int            send_gap_pct = 0;
    int            recv_stall_pct = 0;
    logic          s_taken = 1'b0;

    character_stream_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic char_kind_t char_kind(input logic [7:0] c);
        if (c == cst_pkg::CHAR_SPACE || (c >= cst_pkg::CHAR_TAB && c <= cst_pkg::CHAR_CR))
            return CK_SPACE;
        if (c == cst_pkg::CHAR_TILDE) return CK_TILDE;
        if ((c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90) ||
            c == cst_pkg::CHAR_UNDERSCORE)
            return CK_LEAD;
        if (c >= 8'd48 && c <= 8'd57) return CK_DIGIT;
        if (c == cst_pkg::CHAR_DOT) return CK_DOT;
        return CK_OTHER;
    endfunction

    function automatic logic kw_byte_ok(input logic [63:0] word, input logic [3:0] len,
                                        input logic [7:0] pos, input logic [7:0] c);
        if (pos >= 8'(len) || pos >= 8'(KEYWORD_BYTES)) return 1'b0;
        return word[pos*8 +: 8] == c;
    endfunction

    function automatic void emit_token(input logic [2:0] kind, input logic [7:0] ch,
                                       input logic [7:0] len);
        cst_pkg::out_t t;
        t.token_kind   = kind;
        t.token_char   = ch;
        t.token_length = len;
        t.last         = 1'b0;
        tokens_due = {tokens_due, t};
    endfunction

    // report the pending identifier or number, then go back to idle
    function automatic int close_token();
        int n;
        n = 0;
        if (scan_st == SCAN_IDENT) begin
            if (kw1_hit && tok_len == 8'(kw1_len))
                emit_token(cst_pkg::KIND_KW1, 8'd0, tok_len);
            else if (kw2_hit && tok_len == 8'(kw2_len))
                emit_token(cst_pkg::KIND_KW2, 8'd0, tok_len);
            else
                emit_token(cst_pkg::KIND_IDENT, 8'd0, tok_len);
            n = 1;
        end else if (scan_st == SCAN_NUMBER) begin
            emit_token(cst_pkg::KIND_NUMBER, 8'd0, tok_len);
            n = 1;
        end
        scan_st = SCAN_IDLE;
        tok_len = '0;
        kw1_hit = 1'b0;
        kw2_hit = 1'b0;
        return n;
    endfunction

    task automatic predict_tokens(input cst_pkg::in_t chr);
        char_kind_t ck;
        logic [7:0] c;
        int         n_new;
        bit         absorbed;
        c = chr.char_code;
        ck = char_kind(c);
        n_new = 0;
        absorbed = 0;
        if (chr.end_of_input) begin
            n_new += close_token();
            emit_token(cst_pkg::KIND_END, 8'd0, 8'd0);
            n_new++;
            absorbed = 1;
        end else if (scan_st == SCAN_COMMENT) begin
            if (c == cst_pkg::CHAR_NEWLINE) scan_st = SCAN_IDLE;
            absorbed = 1;
        end else if (scan_st == SCAN_IDENT) begin
            if (ck == CK_LEAD || ck == CK_DIGIT) begin
                kw1_hit = kw1_hit && kw_byte_ok(kw1_word, kw1_len, tok_len, c);
                kw2_hit = kw2_hit && kw_byte_ok(kw2_word, kw2_len, tok_len, c);
                if (tok_len != TOKEN_LEN_MAX) tok_len++;
                absorbed = 1;
            end else begin
                n_new += close_token();
            end
        end else if (scan_st == SCAN_NUMBER) begin
            if (ck == CK_DIGIT || ck == CK_DOT) begin
                if (tok_len != TOKEN_LEN_MAX) tok_len++;
                absorbed = 1;
            end else begin
                n_new += close_token();
            end
        end
        // the character that ended a token starts over from idle
        if (!absorbed) begin
            case (ck)
                CK_SPACE: ;
                CK_TILDE: scan_st = SCAN_COMMENT;
                CK_LEAD: begin
                    scan_st = SCAN_IDENT;
                    kw1_hit = kw_byte_ok(kw1_word, kw1_len, 8'd0, c);
                    kw2_hit = kw_byte_ok(kw2_word, kw2_len, 8'd0, c);
                    tok_len = 8'd1;
                end
                CK_DIGIT, CK_DOT: begin
                    scan_st = SCAN_NUMBER;
                    tok_len = 8'd1;
                end
                default: begin
                    emit_token(cst_pkg::KIND_SINGLE, c, 8'd1);
                    n_new++;
                end
            endcase
        end
        if (n_new > 0) begin
            tokens_due[tokens_due.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_token(input cst_pkg::out_t got);
        cst_pkg::out_t want;
        if (tokens_due.size() == 0) begin
            $error("unexpected token: token_kind %0d token_char %0d token_length %0d",
                   got.token_kind, got.token_char, got.token_length);
            mismatches++;
        end else begin
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
                mismatches++;
            end
            if (got.token_char !== want.token_char) begin
                $error("token_char: expected %0d, got %0d", want.token_char, got.token_char);
                mismatches++;
            end
            if (got.token_length !== want.token_length) begin
                $error("token_length: expected %0d, got %0d",
                       want.token_length, got.token_length);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    // monitor: checks results and predicts on every accepted character
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_token(m_data);
            if (s_valid && s_ready) begin
                predict_tokens(s_data);
                items_taken++;
            end
            s_taken <= s_valid && s_ready;
        end else begin
            s_taken <= 1'b0;
        end
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            if (char_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                s_data  <= char_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic queue_char(input logic [7:0] c, input bit counted = 1'b1);
        cst_pkg::in_t chr;
        chr.char_code = c;
        chr.end_of_input = 1'b0;
        char_q = {char_q, chr};
        items_queued++;
        if (counted) items_counted++;
    endtask

    task automatic queue_end();
        cst_pkg::in_t chr;
        chr.char_code = 8'($urandom_range(255));
        chr.end_of_input = 1'b1;
        char_q = {char_q, chr};
        items_queued++;
        items_counted++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_char(s[i]);
    endtask

    function automatic logic [7:0] pick_word_char(input bit lead);
        int r;
        r = lead ? int'($urandom_range(52)) : int'($urandom_range(62));
        if (r < 26) return 8'(97 + r);
        if (r < 52) return 8'(65 + r - 26);
        if (r == 52) return cst_pkg::CHAR_UNDERSCORE;
        return 8'(48 + r - 53);
    endfunction

    function automatic logic [7:0] pick_num_char();
        int r;
        r = int'($urandom_range(10));
        return (r == 10) ? cst_pkg::CHAR_DOT : 8'(48 + r);
    endfunction

    function automatic logic [7:0] pick_other();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (char_kind(c) != CK_OTHER);
        return c;
    endfunction

    function automatic logic [63:0] rand_keyword();
        logic [63:0] w;
        w[7:0] = pick_word_char(1'b1);
        for (int i = 1; i < 8; i++) w[i*8 +: 8] = pick_word_char(1'b0);
        return w;
    endfunction

    // spell out a configured keyword, optionally cut short or extended
    task automatic queue_keyword(input bit use_kw2, input int trim, input int extra);
        logic [63:0] w;
        int          nb;
        w = use_kw2 ? kw2_word : kw1_word;
        nb = use_kw2 ? int'(kw2_len) : int'(kw1_len);
        if (nb > KEYWORD_BYTES) nb = KEYWORD_BYTES;
        nb -= trim;
        for (int i = 0; i < nb; i++) queue_char(w[i*8 +: 8]);
        repeat (extra) queue_char(pick_word_char(1'b0));
    endtask

    task automatic queue_piece();
        int         pick;
        logic [7:0] c;
        pick = int'($urandom_range(99));
        if (pick < 15) begin
            queue_keyword(1'($urandom_range(1)), 0, 0);
        end else if (pick < 25) begin
            if ($urandom_range(1))
                queue_keyword(1'($urandom_range(1)), int'($urandom_range(1, 2)), 0);
            else
                queue_keyword(1'($urandom_range(1)), 0, int'($urandom_range(1, 3)));
        end else if (pick < 45) begin
            queue_char(pick_word_char(1'b1));
            repeat ($urandom_range(11)) queue_char(pick_word_char(1'b0));
        end else if (pick < 58) begin
            repeat ($urandom_range(1, 8)) queue_char(pick_num_char());
        end else if (pick < 68) begin
            queue_char(pick_other());
        end else if (pick < 76) begin
            repeat ($urandom_range(1, 3)) queue_char(8'($urandom_range(9, 13)), 1'b0);
        end else if (pick < 84) begin
            queue_char(cst_pkg::CHAR_TILDE, 1'b0);
            repeat ($urandom_range(6)) begin
                do c = 8'($urandom_range(255)); while (c == cst_pkg::CHAR_NEWLINE);
                queue_char(c, 1'b0);
            end
            // a comment sometimes runs into the end marker
            if ($urandom_range(4) == 0) queue_end();
            else queue_char(cst_pkg::CHAR_NEWLINE, 1'b0);
        end else if (pick < 91) begin
            queue_end();
        end else begin
            repeat ($urandom_range(1, 4)) queue_char(8'($urandom_range(255)));
        end
        if ($urandom_range(1)) queue_char(cst_pkg::CHAR_SPACE, 1'b0);
    endtask

    task automatic queue_random(input int n_items);
        items_counted = 0;
        while (items_counted < n_items) queue_piece();
    endtask

    // every character accepted and every token seen, then a short settle
    task automatic wait_idle();
        while (items_taken != items_queued || tokens_due.size() != 0) @(negedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [63:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            cst_pkg::CFG_KW1:     kw1_word = data;
            cst_pkg::CFG_KW1_LEN: kw1_len  = data[3:0];
            cst_pkg::CFG_KW2:     kw2_word = data;
            cst_pkg::CFG_KW2_LEN: kw2_len  = data[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_keywords(input logic [63:0] w1, input logic [3:0] l1,
                                input logic [63:0] w2, input logic [3:0] l2);
        write_reg(cst_pkg::CFG_KW1, w1);
        write_reg(cst_pkg::CFG_KW1_LEN, 64'(l1));
        write_reg(cst_pkg::CFG_KW2, w2);
        write_reg(cst_pkg::CFG_KW2_LEN, 64'(l2));
    endtask

    initial begin
        logic [63:0] shared_kw;
        send_gap_pct = 30;
        recv_stall_pct = 57;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: keywords ended by another token, odd bytes, comments, end marker
        queue_text("funk(dih");
        queue_char(8'hFF);
        queue_text("_Z.9");
        queue_char(8'h00);
        queue_char(cst_pkg::CHAR_TAB);
        queue_text("~x");
        queue_char(cst_pkg::CHAR_NEWLINE);
        queue_char(cst_pkg::CHAR_TILDE);
        queue_end();
        queue_text("di");
        queue_end();
        queue_char(8'd113);
        queue_end();

        // saturating lengths: keyword prefix grown long, then a long number
        queue_keyword(1'b0, 0, 256);
        queue_char(cst_pkg::CHAR_SPACE);
        repeat (257) queue_char(pick_num_char());
        queue_char(pick_other());
        queue_random(200);
        wait_idle();

        set_keywords(rand_keyword(), 4'd8, 64'h61, 4'd1);
        queue_random(220);
        wait_idle();

        send_gap_pct = 57;
        recv_stall_pct = 30;
        // zero length and over-long lengths never match
        set_keywords(rand_keyword(), 4'd0, '1, 4'd15);
        queue_random(220);
        wait_idle();

        set_keywords('0, 4'd1, rand_keyword(), 4'($urandom_range(2, 7)));
        queue_random(220);
        wait_idle();

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_keywords(rand_keyword(), 4'd9, rand_keyword(), 4'd5);
        queue_random(220);
        wait_idle();

        // both keywords equal: the first one wins
        shared_kw = rand_keyword();
        set_keywords(shared_kw, 4'd8, shared_kw, 4'd8);
        queue_random(220);
        wait_idle();

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
